// ===== hdl/spi_clock_divider_search_macros.svh =====
// Assertion helpers shared by the search block.
`ifndef SPI_CLOCK_DIVIDER_SEARCH_MACROS_SVH
`define SPI_CLOCK_DIVIDER_SEARCH_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scdiv assertion failed");

// Next-cycle implication, checked out of reset.
`define SCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scdiv assertion failed");

`endif

// ===== hdl/scdiv_pkg.sv =====
package scdiv_pkg;

    localparam int SRC_W  = 28;
    localparam int REQ_W  = 32;
    localparam int PRE_W  = 5;
    localparam int DIV_W  = 7;
    localparam int HIGH_W = 5;

    localparam logic [SRC_W-1:0] SRC_RESET = 28'd80000000;

    // Job queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [REQ_W-1:0] requested_hz;
        logic             bypass;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_head;

    typedef struct packed {
        logic              bypass;
        logic [PRE_W-1:0]  prescale;
        logic [DIV_W-1:0]  divide_count;
        logic [HIGH_W-1:0] high_count;
        logic [SRC_W-1:0]  achieved_hz;
        logic              none_fit;
    } t_result;

endpackage

// ===== hdl/scdiv_front.sv =====
`include "spi_clock_divider_search_macros.svh"

module scdiv_front
    import scdiv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [SRC_W-1:0] i_source_hz,
    input  logic             i_in_valid,
    input  logic [REQ_W-1:0] i_requested_hz,
    output logic             o_in_stall,
    input  logic             i_pop,
    output t_job_head        o_head
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic              push;
    logic              pop;
    t_job              new_job;

    assign o_in_stall = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && (r_count != '0);

    // Classify on entry: a request at or above the source skips the search.
    always_comb begin
        new_job.requested_hz = i_requested_hz;
        new_job.bypass       = (i_requested_hz >= REQ_W'(i_source_hz));
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= new_job;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rd_ptr];

    `SCD_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, push && !pop, r_count == $past(r_count) + QCNT_W'(1))
    `SCD_ASSERT_NEXT(a_count_down, i_clk, i_rst_n, pop && !push, r_count == $past(r_count) - QCNT_W'(1))

endmodule

// ===== hdl/scdiv_divpipe.sv =====
module scdiv_divpipe
    import scdiv_pkg::*;
#(
    parameter int PROD_W = 11,
    parameter int SIDE_W = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [SRC_W-1:0]  i_dividend,
    input  logic [PROD_W-1:0] i_divisor,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [SRC_W-1:0]  o_quotient,
    output logic [SIDE_W-1:0] o_side
);

    // One quotient bit per stage, most significant first.
    localparam int STAGES = SRC_W;

    logic [STAGES-1:0] r_valid;
    logic [PROD_W-1:0] r_rem  [STAGES];
    logic [PROD_W-1:0] r_den  [STAGES];
    logic [SRC_W-1:0]  r_num  [STAGES];
    logic [SRC_W-1:0]  r_quo  [STAGES];
    logic [SIDE_W-1:0] r_side [STAGES];

    logic [STAGES-1:0] n_valid;
    logic [PROD_W-1:0] n_rem  [STAGES];
    logic [PROD_W-1:0] n_den  [STAGES];
    logic [SRC_W-1:0]  n_num  [STAGES];
    logic [SRC_W-1:0]  n_quo  [STAGES];
    logic [SIDE_W-1:0] n_side [STAGES];

    always_comb begin
        logic [PROD_W-1:0] in_rem;
        logic [PROD_W-1:0] in_den;
        logic [SRC_W-1:0]  in_num;
        logic [SRC_W-1:0]  in_quo;
        logic [PROD_W:0]   shifted;
        logic [PROD_W:0]   diff;
        logic              fits;
        for (int s = 0; s < STAGES; s++) begin
            if (s == 0) begin
                n_valid[s] = i_valid;
                in_rem     = '0;
                in_den     = i_divisor;
                in_num     = i_dividend;
                in_quo     = '0;
                n_side[s]  = i_side;
            end else begin
                n_valid[s] = r_valid[s-1];
                in_rem     = r_rem[s-1];
                in_den     = r_den[s-1];
                in_num     = r_num[s-1];
                in_quo     = r_quo[s-1];
                n_side[s]  = r_side[s-1];
            end
            shifted   = {in_rem, in_num[SRC_W-1]};
            diff      = shifted - {1'b0, in_den};
            fits      = (shifted >= {1'b0, in_den});
            n_rem[s]  = fits ? diff[PROD_W-1:0] : shifted[PROD_W-1:0];
            n_den[s]  = in_den;
            n_num[s]  = {in_num[SRC_W-2:0], 1'b0};
            n_quo[s]  = {in_quo[SRC_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < STAGES; s++) begin
            r_rem[s]  <= n_rem[s];
            r_den[s]  <= n_den[s];
            r_num[s]  <= n_num[s];
            r_quo[s]  <= n_quo[s];
            r_side[s] <= n_side[s];
        end
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_valid    = r_valid[STAGES-1];
    assign o_quotient = r_quo[STAGES-1];
    assign o_side     = r_side[STAGES-1];

endmodule

// ===== hdl/scdiv_back.sv =====
`include "spi_clock_divider_search_macros.svh"

module scdiv_back
    import scdiv_pkg::*;
#(
    parameter int MAX_PRESCALE = 16,
    parameter int MAX_DIVIDE   = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [SRC_W-1:0] i_source_hz,
    input  t_job_head        i_head,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_result          o_result
);

    localparam int PC_W   = $clog2(MAX_PRESCALE + 1);
    localparam int DC_W   = $clog2(MAX_DIVIDE + 1);
    localparam int PROD_W = $clog2(MAX_PRESCALE * MAX_DIVIDE + 1);
    localparam int SIDE_W = 1 + PC_W + DC_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_DRAIN = 4'b0100,
        S_WRITE = 4'b1000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic              r_bypass;
    logic              n_bypass;
    logic [REQ_W-1:0]  r_req;
    logic [REQ_W-1:0]  n_req;
    logic [PC_W-1:0]   r_pre;
    logic [PC_W-1:0]   n_pre;
    logic [DC_W-1:0]   r_cnt;
    logic [DC_W-1:0]   n_cnt;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;
    logic [SRC_W-1:0]  r_lead_hz;
    logic [SRC_W-1:0]  n_lead_hz;
    logic [PC_W-1:0]   r_lead_pre;
    logic [PC_W-1:0]   n_lead_pre;
    logic [DC_W-1:0]   r_lead_cnt;
    logic [DC_W-1:0]   n_lead_cnt;
    logic              r_out_valid;
    logic              n_out_valid;
    t_result           r_out;
    t_result           n_out;

    logic              issue_valid;
    logic              issue_last;
    logic [SIDE_W-1:0] issue_side;
    logic              pipe_valid;
    logic [SRC_W-1:0]  pipe_rate;
    logic [SIDE_W-1:0] pipe_side;
    logic              pipe_last;
    logic [PC_W-1:0]   pipe_pre;
    logic [DC_W-1:0]   pipe_cnt;
    logic              better;
    logic              out_free;
    logic [PC_W-1:0]   pre_next;
    logic [DC_W-1:0]   half_m1;
    logic [31:0]       pre_ext;
    logic [31:0]       cnt_ext;
    logic [31:0]       half_ext;

    assign issue_valid = (r_state == S_ISSUE);
    assign issue_last  = (r_pre == PC_W'(MAX_PRESCALE)) && (r_cnt == DC_W'(MAX_DIVIDE));
    assign issue_side  = {issue_last, r_pre, r_cnt};
    assign pre_next    = r_pre + PC_W'(1);

    scdiv_divpipe #(
        .PROD_W (PROD_W),
        .SIDE_W (SIDE_W)
    ) u_divpipe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (issue_valid),
        .i_dividend (i_source_hz),
        .i_divisor  (r_prod),
        .i_side     (issue_side),
        .o_valid    (pipe_valid),
        .o_quotient (pipe_rate),
        .o_side     (pipe_side)
    );

    assign pipe_cnt  = pipe_side[DC_W-1:0];
    assign pipe_pre  = pipe_side[DC_W +: PC_W];
    assign pipe_last = pipe_side[SIDE_W-1];

    // Strictly higher keeps the first pair in scan order on ties.
    assign better   = pipe_valid && (REQ_W'(pipe_rate) <= r_req) && (pipe_rate > r_lead_hz);
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == S_IDLE) && i_head.valid;

    assign half_m1  = (r_lead_cnt >> 1) - DC_W'(1);
    assign pre_ext  = 32'(r_lead_pre);
    assign cnt_ext  = 32'(r_lead_cnt);
    assign half_ext = 32'(half_m1);

    always_comb begin
        n_state     = r_state;
        n_bypass    = r_bypass;
        n_req       = r_req;
        n_pre       = r_pre;
        n_cnt       = r_cnt;
        n_prod      = r_prod;
        n_lead_hz   = r_lead_hz;
        n_lead_pre  = r_lead_pre;
        n_lead_cnt  = r_lead_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        if (better) begin
            n_lead_hz  = pipe_rate;
            n_lead_pre = pipe_pre;
            n_lead_cnt = pipe_cnt;
        end

        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    n_bypass   = i_head.job.bypass;
                    n_req      = i_head.job.requested_hz;
                    n_pre      = PC_W'(1);
                    n_cnt      = DC_W'(2);
                    n_prod     = PROD_W'(2);
                    n_lead_hz  = '0;
                    n_lead_pre = PC_W'(MAX_PRESCALE);
                    n_lead_cnt = DC_W'(MAX_DIVIDE);
                    n_state    = i_head.job.bypass ? S_WRITE : S_ISSUE;
                end
            end
            S_ISSUE: begin
                // Advance the counter divisor inside, the prescaler outside.
                if (issue_last) begin
                    n_state = S_DRAIN;
                end else if (r_cnt == DC_W'(MAX_DIVIDE)) begin
                    n_pre  = pre_next;
                    n_cnt  = DC_W'(2);
                    n_prod = PROD_W'({pre_next, 1'b0});
                end else begin
                    n_cnt  = r_cnt + DC_W'(1);
                    n_prod = r_prod + PROD_W'(r_pre);
                end
            end
            S_DRAIN: begin
                if (pipe_valid && pipe_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (out_free) begin
                    if (r_bypass) begin
                        n_out.bypass       = 1'b1;
                        n_out.prescale     = '0;
                        n_out.divide_count = '0;
                        n_out.high_count   = '0;
                        n_out.achieved_hz  = i_source_hz;
                        n_out.none_fit     = 1'b0;
                    end else begin
                        n_out.bypass       = 1'b0;
                        n_out.prescale     = pre_ext[PRE_W-1:0];
                        n_out.divide_count = cnt_ext[DIV_W-1:0];
                        n_out.high_count   = half_ext[HIGH_W-1:0];
                        n_out.achieved_hz  = r_lead_hz;
                        n_out.none_fit     = (r_lead_hz == '0);
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bypass   <= n_bypass;
        r_req      <= n_req;
        r_pre      <= n_pre;
        r_cnt      <= n_cnt;
        r_prod     <= n_prod;
        r_lead_hz  <= n_lead_hz;
        r_lead_pre <= n_lead_pre;
        r_lead_cnt <= n_lead_cnt;
        r_out      <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    `SCD_ASSERT_NOW(a_pipe_in_search, i_clk, i_rst_n, pipe_valid, (r_state == S_ISSUE) || (r_state == S_DRAIN))
    `SCD_ASSERT_NOW(a_none_fit_zero, i_clk, i_rst_n, r_out_valid && r_out.none_fit, (r_out.achieved_hz == '0) && !r_out.bypass)

endmodule

// ===== hdl/spi_clock_divider_search.sv =====
// Clock divider search. Each request on the input channel is a highest allowed
// bit rate in hertz; the block answers with one result: the prescaler
// (1 to MAX_PRESCALE) and counter divisor (2 to MAX_DIVIDE) whose rate,
// source / (prescale * divide) rounded down, is the highest not above the
// request, taking the first such pair with the prescaler as the outer scan.
// A request at or above the source rate returns bypass with the source rate.
// When no pair gives a nonzero rate within the request, the defaults
// MAX_PRESCALE / MAX_DIVIDE come back with achieved rate 0 and none_fit set.
// A searched request leaves the queue, issues one prescaler/counter pair per
// cycle into the pipelined divider, drains the divider and then loads the
// output register; the next search starts only once this one is done. A
// bypassed request skips the scan and goes from the queue straight to the
// output register. A result held by the output stall delays the next load. A
// two-entry queue in front of the search lets new requests be taken while a
// search runs, and the output register lets the next search start while a
// result waits. The source frequency register (reset 80 MHz) is written
// through the configuration channel; the user must write it only while the
// block is idle, and the block itself does not enforce this.
module spi_clock_divider_search
    import scdiv_pkg::*;
#(
    parameter int MAX_PRESCALE = 16,
    parameter int MAX_DIVIDE   = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    // configuration channel: source frequency in hertz
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SRC_W-1:0]  i_cfg_data,

    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [REQ_W-1:0]  i_requested_hz,

    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_bypass,
    output logic [PRE_W-1:0]  o_prescale,
    output logic [DIV_W-1:0]  o_divide_count,
    output logic [HIGH_W-1:0] o_high_count,
    output logic [SRC_W-1:0]  o_achieved_hz,
    output logic              o_none_fit
);

    logic [SRC_W-1:0] r_source_hz;
    t_job_head        head;
    logic             pop;
    t_result          result;

    // The register takes every write transfer at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_hz <= SRC_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_source_hz <= i_cfg_data;
        end
    end

    // Front: take each request transfer, mark bypass, queue it.
    scdiv_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_source_hz    (r_source_hz),
        .i_in_valid     (i_in_valid),
        .i_requested_hz (i_requested_hz),
        .o_in_stall     (o_in_stall),
        .i_pop          (pop),
        .o_head         (head)
    );

    // Back: scan the pairs through the divider pipeline, hold the result.
    scdiv_back #(
        .MAX_PRESCALE (MAX_PRESCALE),
        .MAX_DIVIDE   (MAX_DIVIDE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_source_hz (r_source_hz),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_bypass       = result.bypass;
    assign o_prescale     = result.prescale;
    assign o_divide_count = result.divide_count;
    assign o_high_count   = result.high_count;
    assign o_achieved_hz  = result.achieved_hz;
    assign o_none_fit     = result.none_fit;

endmodule

// ===== sim/spi_clock_divider_search_test.sv =====
module spi_clock_divider_search_test
    import scdiv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRESCALE     = 16;
    localparam int MAX_DIVIDE       = 64;
    localparam int RESET_CYCLES     = 10;
    localparam int RATES_PER_PHASE  = 94;
    localparam int SETTLE_CYCLES    = 8;
    localparam int DRAIN_CYCLES     = 40;
    // Slowest correct run: about 600 full searches, plus sender and receiver
    // gaps; take that several times over.
    localparam int CYCLE_LIMIT      = 3_000_000;

    // Source rates loaded at each phase boundary, extremes first.
    localparam logic [SRC_W-1:0] SRC_LOWEST  = 28'd1000000;
    localparam logic [SRC_W-1:0] SRC_HIGHEST = 28'd240000000;

    typedef struct {
        logic [REQ_W-1:0] requested_hz;
        bit               drain_first;   // hold off until every result is back
    } t_rate_request;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [SRC_W-1:0]  i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [REQ_W-1:0]  i_requested_hz = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_bypass;
    logic [PRE_W-1:0]  o_prescale;
    logic [DIV_W-1:0]  o_divide_count;
    logic [HIGH_W-1:0] o_high_count;
    logic [SRC_W-1:0]  o_achieved_hz;
    logic              o_none_fit;

    // Testbench copy of the source frequency register.
    logic [SRC_W-1:0]  source_setting = SRC_RESET;

    t_rate_request     pending_requests[$];
    t_result           expected_settings[$];
    int                error_count = 0;
    int                cycle_count = 0;
    int                send_wait = 0;
    int                recv_wait = 0;
    bit                send_burst = 1'b0;
    bit                recv_burst = 1'b0;

    spi_clock_divider_search #(
        .MAX_PRESCALE(MAX_PRESCALE),
        .MAX_DIVIDE  (MAX_DIVIDE)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_requested_hz(i_requested_hz),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_bypass      (o_bypass),
        .o_prescale    (o_prescale),
        .o_divide_count(o_divide_count),
        .o_high_count  (o_high_count),
        .o_achieved_hz (o_achieved_hz),
        .o_none_fit    (o_none_fit)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Scan every prescaler/counter pair, prescaler outermost, and keep the
    // first pair reaching the highest nonzero rate not above the request.
    function automatic t_result predict_divider(logic [REQ_W-1:0] req,
                                                logic [SRC_W-1:0] src);
        t_result     res;
        int unsigned rate;
        int unsigned lead_pre;
        int unsigned lead_cnt;
        int unsigned lead_hz;
        res = '0;
        if (req >= src) begin
            // Bypass: dividers unused, the source rate goes straight out.
            res.bypass      = 1'b1;
            res.achieved_hz = src;
            return res;
        end
        lead_pre = MAX_PRESCALE;
        lead_cnt = MAX_DIVIDE;
        lead_hz  = 0;
        for (int unsigned pre = 1; pre <= MAX_PRESCALE; pre++) begin
            for (int unsigned cnt = 2; cnt <= MAX_DIVIDE; cnt++) begin
                rate = 32'(src) / (pre * cnt);
                // A rate that rounds down to zero never beats lead_hz of 0.
                if (rate <= req && rate > lead_hz) begin
                    lead_hz  = rate;
                    lead_pre = pre;
                    lead_cnt = cnt;
                end
            end
        end
        res.prescale     = PRE_W'(lead_pre);
        res.divide_count = DIV_W'(lead_cnt);
        res.high_count   = HIGH_W'(lead_cnt / 2 - 1);
        res.achieved_hz  = SRC_W'(lead_hz);
        res.none_fit     = (lead_hz == 0);
        return res;
    endfunction

    // Draw a random wait between transfers; bursts run with no idling at all.
    function automatic int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(5, 0);
    endfunction

    // Pick a request aimed at one region of the search relative to src.
    function automatic logic [REQ_W-1:0] pick_request(logic [SRC_W-1:0] src);
        int unsigned kind;
        int unsigned src_hz;
        int unsigned pair_rate;
        src_hz = 32'(src);
        kind   = $urandom_range(99, 0);
        if (kind < 10) begin
            return $urandom_range(32'hFFFF_FFFF, src_hz);          // bypass
        end else if (kind < 18) begin
            return $urandom();                                    // any pattern
        end else if (kind < 50) begin
            // Land on, just under or just over the exact rate of some pair.
            pair_rate = src_hz / ($urandom_range(MAX_PRESCALE, 1) *
                                  $urandom_range(MAX_DIVIDE, 2));
            return pair_rate + $urandom_range(2, 0) - 1;
        end else if (kind < 60) begin
            // Around the slowest rate: below it nothing fits.
            return $urandom_range((src_hz / (MAX_PRESCALE * MAX_DIVIDE)) + 1, 0);
        end else if (kind < 68) begin
            return src_hz - $urandom_range(3, 1);                  // just below bypass
        end else begin
            return $urandom_range(src_hz - 1, 0);
        end
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Queue one request for the driver.
    task automatic queue_rate(logic [REQ_W-1:0] req, bit drain_first);
        t_rate_request item;
        item.requested_hz = req;
        item.drain_first  = drain_first;
        pending_requests.push_back(item);
    endtask

    // Sample at the falling edge so the driver and monitor have settled.
    task automatic wait_until_idle();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || i_in_valid ||
               expected_settings.size() != 0);
    endtask

    // Load a new source rate; only called with the block idle.
    task automatic write_source(logic [SRC_W-1:0] src);
        wait_until_idle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= src;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid    <= 1'b0;
        source_setting = src;
        @(negedge i_clk);
    endtask

    task automatic queue_random_phase(int count);
        for (int n = 0; n < count; n++) begin
            // Drain once mid-phase for sure, now and then otherwise.
            queue_rate(pick_request(source_setting),
                       (n == count / 2) || ($urandom_range(49, 0) == 0));
        end
    endtask

    // Driver: present the next pending request once its gap has run out.
    // Hold the payload while stalled; push the prediction on each transfer.
    always @(posedge i_clk) begin
        logic          next_valid;
        t_rate_request item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_settings.push_back(predict_divider(i_requested_hz,
                                                            source_setting));
                next_valid = 1'b0;
                send_wait  = draw_gap(send_burst);
                if ($urandom_range(29, 0) == 0) send_burst = !send_burst;
            end
            if (!next_valid) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_requests.size() != 0 &&
                             (!pending_requests[0].drain_first ||
                              expected_settings.size() == 0)) begin
                    item           = pending_requests.pop_front();
                    i_requested_hz <= item.requested_hz;
                    next_valid     = 1'b1;
                end
            end
            i_in_valid <= next_valid;
        end
    end

    // Monitor: check each result transfer against the oldest prediction,
    // then stall for a drawn number of cycles; toggle stall while idle too so
    // results also arrive into a stall.
    always @(posedge i_clk) begin
        t_result want;
        logic    next_stall;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_settings.size() == 0) begin
                    $error("result transfer with nothing expected, achieved_hz %0d",
                           o_achieved_hz);
                    error_count++;
                end else begin
                    want = expected_settings.pop_front();
                    check_field("bypass", 32'(want.bypass), 32'(o_bypass));
                    check_field("prescale", 32'(want.prescale), 32'(o_prescale));
                    check_field("divide_count", 32'(want.divide_count),
                                32'(o_divide_count));
                    check_field("high_count", 32'(want.high_count), 32'(o_high_count));
                    check_field("achieved_hz", 32'(want.achieved_hz),
                                32'(o_achieved_hz));
                    check_field("none_fit", 32'(want.none_fit), 32'(o_none_fit));
                end
                recv_wait = draw_gap(recv_burst);
                if ($urandom_range(29, 0) == 0) recv_burst = !recv_burst;
            end
            if (recv_wait > 0) begin
                next_stall = 1'b1;
                recv_wait--;
            end else if (!o_out_valid && !recv_burst) begin
                next_stall = ($urandom_range(2, 0) == 0);
            end else begin
                next_stall = 1'b0;
            end
            i_out_stall <= next_stall;
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests at the reset source of 80 MHz.
        queue_rate(32'd0, 1'b0);                 // nothing fits
        queue_rate(32'd1, 1'b0);
        queue_rate(32'd78124, 1'b0);             // one below the slowest rate
        queue_rate(32'd78125, 1'b0);             // exactly the slowest pair
        queue_rate(32'd78126, 1'b0);
        queue_rate(32'd12345, 1'b0);
        queue_rate(32'hFFFF_FFFF, 1'b0);         // all ones, bypass
        queue_rate(32'h8000_0000, 1'b0);
        queue_rate(32'd80000000, 1'b0);          // equal to the source, bypass
        queue_rate(32'd80000001, 1'b0);
        queue_rate(32'd79999999, 1'b0);          // fastest search case
        queue_rate(32'd40000000, 1'b0);          // prescale 1, divide 2
        queue_rate(32'd39999999, 1'b0);
        queue_rate(32'd26666666, 1'b0);
        queue_rate(32'd20000001, 1'b0);
        queue_rate(32'd10000000, 1'b0);          // tie: first pair wins
        queue_rate(32'd5000000, 1'b0);
        queue_rate(32'd1234567, 1'b0);
        queue_rate(32'd1000000, 1'b1);           // after a full drain
        queue_rate(32'h7FFF_FFFF, 1'b0);
        queue_random_phase(RATES_PER_PHASE);

        // Walk the source through its extremes and some random settings.
        write_source(SRC_HIGHEST);
        queue_random_phase(RATES_PER_PHASE);
        write_source(SRC_LOWEST);
        queue_random_phase(RATES_PER_PHASE);
        write_source(SRC_W'($urandom_range(SRC_HIGHEST, SRC_LOWEST)));
        queue_random_phase(RATES_PER_PHASE);
        write_source(SRC_W'($urandom_range(SRC_HIGHEST, SRC_LOWEST)));
        queue_random_phase(RATES_PER_PHASE);
        write_source(SRC_RESET);
        queue_random_phase(RATES_PER_PHASE);

        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_settings.size() != 0) begin
            $error("%0d results never arrived", expected_settings.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
